@@ rtl/rtc_pkg.sv @@
// Shared types, constants and calendar helper functions for the real-time clock calendar.
package rtc_pkg;

    // Operation codes carried in the op field
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SET_DATE = 2'd1,
        OP_SET_TIME = 2'd2,
        OP_HOLD     = 2'd3
    } t_op;

    // Input beat
    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  new_month;
        logic [4:0]  new_day;
        logic [11:0] new_year;
        logic [4:0]  new_hour;
        logic [5:0]  new_minute;
        logic [5:0]  new_second;
    } t_rtc_in;

    // Result beat
    typedef struct packed {
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [11:0] cur_year;
        logic [4:0]  cur_hour;
        logic [5:0]  cur_minute;
        logic [5:0]  cur_second;
        logic [3:0]  hour_twelve;
        logic        is_pm;
    } t_rtc_out;

    localparam logic [11:0] YEAR_MIN     = 12'd1900;
    localparam logic [11:0] YEAR_DEFAULT = 12'd2000;
    localparam logic [11:0] YEAR_MAX     = 12'd4095;
    localparam logic [3:0]  MONTH_FIRST  = 4'd1;
    localparam logic [3:0]  MONTH_LAST   = 4'd12;
    localparam logic [4:0]  DAY_FIRST    = 5'd1;
    localparam logic [4:0]  HOUR_LAST    = 5'd23;
    localparam logic [4:0]  HOUR_NOON    = 5'd12;
    localparam logic [5:0]  MIN_LAST     = 6'd59;
    localparam logic [5:0]  SEC_LAST     = 6'd59;

    // Multiplicative inverse of 25 modulo 2^12; y is a multiple of 25
    // exactly when y * INV25 (mod 2^12) is at most 4095 / 25.
    localparam logic [11:0] INV25        = 12'd3113;
    localparam logic [11:0] DIV25_LIMIT  = 12'd163;

    // Gregorian leap rule: divisible by 400, or by 4 and not by 100
    function automatic logic is_leap(input logic [11:0] year);
        logic [11:0] prod;
        logic        div25;
        prod  = 12'(year * INV25);
        div25 = (prod <= DIV25_LIMIT);
        return ((year[3:0] == 4'd0) && div25) || ((year[1:0] == 2'd0) && !div25);
    endfunction

    // Days in a month; any code outside 1..12 falls to 31
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic [11:0] year);
        logic [4:0] len;
        case (month)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = is_leap(year) ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/calendar_clock_counter.sv @@
// Real-time clock and calendar: input register, single-pass update, two-entry result queue.
// The calendar update is one pass of small-counter carries on the input register's beat.
// Throughput: one beat per cycle while the skid entry is empty, else the input stalls.
// The two-entry result queue lets a new beat enter while an earlier result is stalled.
// Reset: synchronous, active low; date 2000-01-01, time 00:00:00, no beats pending.
module calendar_clock_counter
    import rtc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_rtc_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_rtc_out o_out_data
);

    // Input register
    logic     r_in_valid;
    t_rtc_in  r_in;

    // Calendar state
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [11:0] r_year;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;

    logic [3:0]  n_month;
    logic [4:0]  n_day;
    logic [11:0] n_year;
    logic [4:0]  n_hour;
    logic [5:0]  n_minute;
    logic [5:0]  n_second;

    // Result queue: head and skid entry
    logic     r_out_valid;
    t_rtc_out r_out;
    logic     r_skid_valid;
    t_rtc_out r_skid;

    logic     w_in_acc;
    logic     w_move;
    logic     w_pop;
    t_rtc_out w_res;

    logic [3:0]  w_sd_month;
    logic [11:0] w_sd_year;
    logic [4:0]  w_sd_len;
    logic [4:0]  w_cur_len;

    // Handshake
    assign w_move     = r_in_valid && !r_skid_valid;
    assign w_pop      = r_out_valid && !i_out_stall;
    assign o_in_stall = r_in_valid && !w_move;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_data;
        end
    end

    // Checked values for a date load
    assign w_sd_month = ((r_in.new_month >= MONTH_FIRST) && (r_in.new_month <= MONTH_LAST))
                        ? r_in.new_month : MONTH_FIRST;
    assign w_sd_year  = (r_in.new_year >= YEAR_MIN) ? r_in.new_year : YEAR_DEFAULT;
    assign w_sd_len   = month_len(w_sd_month, w_sd_year);
    assign w_cur_len  = month_len(r_month, r_year);

    // Next calendar state
    always_comb begin
        n_month  = r_month;
        n_day    = r_day;
        n_year   = r_year;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        case (r_in.op)
            OP_TICK: begin
                if (r_second == SEC_LAST) begin
                    n_second = 6'd0;
                    if (r_minute == MIN_LAST) begin
                        n_minute = 6'd0;
                        if (r_hour == HOUR_LAST) begin
                            n_hour = 5'd0;
                            if (r_day >= w_cur_len) begin
                                n_day = DAY_FIRST;
                                if (r_month >= MONTH_LAST) begin
                                    n_month = MONTH_FIRST;
                                    n_year  = (r_year == YEAR_MAX) ? YEAR_MIN : r_year + 12'd1;
                                end else begin
                                    n_month = r_month + 4'd1;
                                end
                            end else begin
                                n_day = r_day + 5'd1;
                            end
                        end else begin
                            n_hour = r_hour + 5'd1;
                        end
                    end else begin
                        n_minute = r_minute + 6'd1;
                    end
                end else begin
                    n_second = r_second + 6'd1;
                end
            end
            OP_SET_DATE: begin
                n_month = w_sd_month;
                n_year  = w_sd_year;
                n_day   = ((r_in.new_day >= DAY_FIRST) && (r_in.new_day <= w_sd_len))
                          ? r_in.new_day : DAY_FIRST;
            end
            OP_SET_TIME: begin
                n_hour   = (r_in.new_hour <= HOUR_LAST) ? r_in.new_hour : 5'd0;
                n_minute = (r_in.new_minute <= MIN_LAST) ? r_in.new_minute : 6'd0;
                n_second = (r_in.new_second <= SEC_LAST) ? r_in.new_second : 6'd0;
            end
            default: begin
            end
        endcase
    end

    // Result beat from the updated state
    always_comb begin
        w_res.cur_month  = n_month;
        w_res.cur_day    = n_day;
        w_res.cur_year   = n_year;
        w_res.cur_hour   = n_hour;
        w_res.cur_minute = n_minute;
        w_res.cur_second = n_second;
        w_res.is_pm      = (n_hour >= HOUR_NOON);
        if (n_hour == 5'd0) begin
            w_res.hour_twelve = 4'd12;
        end else if (n_hour > HOUR_NOON) begin
            w_res.hour_twelve = 4'(n_hour - HOUR_NOON);
        end else begin
            w_res.hour_twelve = 4'(n_hour);
        end
    end

    // Calendar state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_month  <= MONTH_FIRST;
            r_day    <= DAY_FIRST;
            r_year   <= YEAR_DEFAULT;
            r_hour   <= 5'd0;
            r_minute <= 6'd0;
            r_second <= 6'd0;
        end else if (w_move) begin
            r_month  <= n_month;
            r_day    <= n_day;
            r_year   <= n_year;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
        end
    end

    // Result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_out_valid  <= r_skid_valid || w_move;
                r_skid_valid <= 1'b0;
            end else if (w_move) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    // Result queue payload
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_move) begin
            if (r_out_valid) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    // Skid entry is only ever filled behind a waiting head
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without head entry");

    // Time counters stay in range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_second <= SEC_LAST) && (r_minute <= MIN_LAST) && (r_hour <= HOUR_LAST))
        else $error("time counter out of range");

    // Date counters stay in range
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_month >= MONTH_FIRST) && (r_month <= MONTH_LAST) && (r_year >= YEAR_MIN)
        && (r_day >= DAY_FIRST) && (r_day <= w_cur_len))
        else $error("date counter out of range");

    // A tick below the minute boundary steps the second by one
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && (r_in.op == OP_TICK) && (r_second != SEC_LAST))
        |=> (r_second == $past(r_second) + 6'd1))
        else $error("tick did not advance the second");

    // A moved beat always lands in the queue
    a_move_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> r_out_valid)
        else $error("processed beat lost");

endmodule
